// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clock, resetn, ante, cons)
`define ASSERT_NEXT(label, clock, resetn, ante, cons)
`endif
`endif

// ===== hdl/dll_pkg.sv =====
`timescale 1ns / 1ps

package dll_pkg;

    localparam int NUM_W  = 32;
    localparam int LINE_W = 24;
    localparam int OFF_W  = 24;
    localparam int LEN_W  = 16;

    // Lexer modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NAME = 2'd1;
    localparam logic [1:0] MODE_DEC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    // Token kinds
    localparam logic [2:0] KIND_END    = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_SYMBOL = 3'd2;
    localparam logic [2:0] KIND_NAME   = 3'd3;

    // Keyword slots: 0 enum, 1 struct, 2 union
    localparam logic [1:0] KW_ENUM   = 2'd0;
    localparam logic [1:0] KW_STRUCT = 2'd1;
    localparam logic [1:0] KW_UNION  = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]        kind;
        logic [NUM_W-1:0]  value;
        logic [7:0]        sym;
        logic [LINE_W-1:0] line;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
    } token_t;

    // Up to three tokens caused by one input item
    typedef struct packed {
        token_t [2:0] tok;
        logic [1:0]   count;
    } token_group_t;

    typedef struct packed {
        logic              wr;
        logic [LINE_W-1:0] data;
    } cfg_write_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    // Bit 4 set when c is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] h;
        h = 5'd0;
        if (is_digit(c))
        begin
            h = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            h = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return h;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] n;
        case (k)
            KW_ENUM:   n = 3'd4;
            KW_STRUCT: n = 3'd6;
            KW_UNION:  n = 3'd5;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] ch;
        case ({k, idx})
            {KW_ENUM, 3'd0}:   ch = 8'h65; // e
            {KW_ENUM, 3'd1}:   ch = 8'h6E; // n
            {KW_ENUM, 3'd2}:   ch = 8'h75; // u
            {KW_ENUM, 3'd3}:   ch = 8'h6D; // m
            {KW_STRUCT, 3'd0}: ch = 8'h73; // s
            {KW_STRUCT, 3'd1}: ch = 8'h74; // t
            {KW_STRUCT, 3'd2}: ch = 8'h72; // r
            {KW_STRUCT, 3'd3}: ch = 8'h75; // u
            {KW_STRUCT, 3'd4}: ch = 8'h63; // c
            {KW_STRUCT, 3'd5}: ch = 8'h74; // t
            {KW_UNION, 3'd0}:  ch = 8'h75; // u
            {KW_UNION, 3'd1}:  ch = 8'h6E; // n
            {KW_UNION, 3'd2}:  ch = 8'h69; // i
            {KW_UNION, 3'd3}:  ch = 8'h6F; // o
            {KW_UNION, 3'd4}:  ch = 8'h6E; // n
            default:           ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/dll_core.sv =====
`timescale 1ns / 1ps

module dll_core #(
    parameter int VALUE_WIDTH    = 32,
    parameter int POSITION_WIDTH = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  has_byte,
    input  logic [7:0]            in_byte,
    input  logic                  is_last,
    input  logic                  group_free,
    input  dll_pkg::cfg_write_t   cfg,
    output logic                  item_take,
    output dll_pkg::token_group_t group
);

    localparam int VC = (VALUE_WIDTH < dll_pkg::NUM_W) ? VALUE_WIDTH : dll_pkg::NUM_W;
    localparam int PC = (POSITION_WIDTH < dll_pkg::OFF_W) ? POSITION_WIDTH : dll_pkg::OFF_W;

    logic [1:0]                    mode_reg, mode_next;
    logic [VALUE_WIDTH-1:0]        acc_reg, acc_next;
    logic                          neg_reg, neg_next;
    logic [2:0]                    kw_reg, kw_next;
    logic [dll_pkg::LINE_W-1:0]    line_reg, line_next;
    logic [POSITION_WIDTH-1:0]     pos_reg, pos_next;
    logic [POSITION_WIDTH-1:0]     start_pos_reg, start_pos_next;
    logic [dll_pkg::LINE_W-1:0]    start_line_reg, start_line_next;
    logic [dll_pkg::LEN_W-1:0]     len_reg, len_next;
    logic                          fresh_reg, fresh_next;
    logic [dll_pkg::LINE_W-1:0]    first_line_reg;
    logic [4:0]                    hex;
    logic                          extend;
    logic [1:0]                    n;

    function automatic logic [dll_pkg::OFF_W-1:0] to_offset(input logic [POSITION_WIDTH-1:0] p);
        return dll_pkg::OFF_W'(p[PC-1:0]);
    endfunction

    // Build the token for a name or number being closed
    function automatic dll_pkg::token_t finish_tok(
        input logic [1:0]                 mode,
        input logic [2:0]                 kw,
        input logic [dll_pkg::LEN_W-1:0]  len,
        input logic [VALUE_WIDTH-1:0]     acc,
        input logic                       neg,
        input logic [dll_pkg::LINE_W-1:0] sline,
        input logic [POSITION_WIDTH-1:0]  spos
    );
        dll_pkg::token_t        t;
        logic [VALUE_WIDTH-1:0] v;
        t = '0;
        v = neg ? -acc : acc;
        t.line   = sline;
        t.offset = to_offset(spos);
        t.length = len;
        if (mode == dll_pkg::MODE_NAME)
        begin
            t.kind = dll_pkg::KIND_NAME;
            for (int k = 0; k < 3; k++)
            begin
                if (kw[k] && len == dll_pkg::LEN_W'(dll_pkg::kw_len(2'(k))))
                begin
                    t.kind = 3'(dll_pkg::KIND_NAME + 3'd1 + 3'(k));
                end
            end
        end
        else
        begin
            t.kind  = dll_pkg::KIND_NUMBER;
            t.value = dll_pkg::NUM_W'(v[VC-1:0]);
        end
        return t;
    endfunction

    // Step the lexer over one item and collect its tokens
    always_comb
    begin
        mode_next       = mode_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        kw_next         = kw_reg;
        line_next       = line_reg;
        pos_next        = pos_reg;
        start_pos_next  = start_pos_reg;
        start_line_next = start_line_reg;
        len_next        = len_reg;
        fresh_next      = fresh_reg;
        group           = '0;
        n               = 2'd0;
        extend          = 1'b0;
        hex             = dll_pkg::hex_digit(in_byte);

        if (has_byte)
        begin
            // extend the open token if the byte fits it
            case (mode_reg)
                dll_pkg::MODE_NAME:
                begin
                    if (dll_pkg::is_alpha(in_byte) || dll_pkg::is_digit(in_byte) ||
                        in_byte == dll_pkg::CH_UNDER)
                    begin
                        extend = 1'b1;
                        for (int k = 0; k < 3; k++)
                        begin
                            if (len_reg >= dll_pkg::LEN_W'(dll_pkg::kw_len(2'(k))) ||
                                dll_pkg::kw_char(2'(k), len_reg[2:0]) != in_byte)
                            begin
                                kw_next[k] = 1'b0;
                            end
                        end
                    end
                end
                dll_pkg::MODE_DEC:
                begin
                    if (dll_pkg::is_digit(in_byte))
                    begin
                        extend   = 1'b1;
                        acc_next = (acc_reg << 3) + (acc_reg << 1) +
                                   VALUE_WIDTH'(in_byte[3:0]);
                    end
                end
                dll_pkg::MODE_HEX:
                begin
                    if (hex[4])
                    begin
                        extend   = 1'b1;
                        acc_next = (acc_reg << 4) | VALUE_WIDTH'(hex[3:0]);
                    end
                end
                default:
                begin
                    extend = 1'b0;
                end
            endcase

            if (extend)
            begin
                len_next = (len_reg == dll_pkg::LEN_MAX) ? len_reg
                                                          : len_reg + dll_pkg::LEN_W'(1);
            end
            else
            begin
                // close the open token
                if (mode_reg != dll_pkg::MODE_IDLE)
                begin
                    group.tok[n] = finish_tok(mode_reg, kw_reg, len_reg, acc_reg, neg_reg,
                                              start_line_reg, start_pos_reg);
                    n = n + 2'd1;
                end
                mode_next = dll_pkg::MODE_IDLE;
                acc_next  = '0;
                neg_next  = 1'b0;
                kw_next   = 3'b000;
                len_next  = '0;

                // start a new token from idle, or emit a symbol token
                if (dll_pkg::is_space(in_byte))
                begin
                    if (in_byte == dll_pkg::CH_NEWLINE)
                    begin
                        line_next = line_reg + dll_pkg::LINE_W'(1);
                    end
                end
                else if (dll_pkg::is_alpha(in_byte) || in_byte == dll_pkg::CH_UNDER)
                begin
                    mode_next       = dll_pkg::MODE_NAME;
                    start_pos_next  = pos_reg;
                    start_line_next = line_reg;
                    len_next        = dll_pkg::LEN_W'(1);
                    for (int k = 0; k < 3; k++)
                    begin
                        kw_next[k] = (dll_pkg::kw_char(2'(k), 3'd0) == in_byte);
                    end
                end
                else if (dll_pkg::is_digit(in_byte) || in_byte == dll_pkg::CH_MINUS)
                begin
                    mode_next       = dll_pkg::MODE_DEC;
                    start_pos_next  = pos_reg;
                    start_line_next = line_reg;
                    len_next        = dll_pkg::LEN_W'(1);
                    neg_next        = (in_byte == dll_pkg::CH_MINUS);
                    acc_next        = (in_byte == dll_pkg::CH_MINUS) ? '0
                                      : VALUE_WIDTH'(in_byte[3:0]);
                end
                else if (in_byte == dll_pkg::CH_DOLLAR)
                begin
                    mode_next       = dll_pkg::MODE_HEX;
                    start_pos_next  = pos_reg;
                    start_line_next = line_reg;
                    len_next        = dll_pkg::LEN_W'(1);
                end
                else
                begin
                    group.tok[n].kind   = dll_pkg::KIND_SYMBOL;
                    group.tok[n].sym    = in_byte;
                    group.tok[n].line   = line_reg;
                    group.tok[n].offset = to_offset(pos_reg);
                    group.tok[n].length = dll_pkg::LEN_W'(1);
                    n = n + 2'd1;
                end
            end
            pos_next   = pos_reg + POSITION_WIDTH'(1);
            fresh_next = 1'b0;
        end

        if (is_last)
        begin
            // close any open token, emit the end token, begin a new stream
            if (mode_next != dll_pkg::MODE_IDLE)
            begin
                group.tok[n] = finish_tok(mode_next, kw_next, len_next, acc_next, neg_next,
                                          start_line_next, start_pos_next);
                n = n + 2'd1;
            end
            group.tok[n].kind   = dll_pkg::KIND_END;
            group.tok[n].line   = line_next;
            group.tok[n].offset = to_offset(pos_next);
            n = n + 2'd1;

            mode_next       = dll_pkg::MODE_IDLE;
            acc_next        = '0;
            neg_next        = 1'b0;
            kw_next         = 3'b000;
            line_next       = first_line_reg;
            pos_next        = '0;
            start_pos_next  = '0;
            start_line_next = '0;
            len_next        = '0;
            fresh_next      = 1'b1;
        end
        group.count = n;
    end

    // Take the item when its tokens have room, or when it has none
    assign item_take = item_valid && (group.count == 2'd0 || group_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= dll_pkg::MODE_IDLE;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            kw_reg         <= 3'b000;
            line_reg       <= dll_pkg::LINE_W'(1);
            pos_reg        <= '0;
            start_pos_reg  <= '0;
            start_line_reg <= '0;
            len_reg        <= '0;
            fresh_reg      <= 1'b1;
            first_line_reg <= dll_pkg::LINE_W'(1);
        end
        else
        begin
            if (cfg.wr)
            begin
                first_line_reg <= cfg.data;
            end
            if (item_take)
            begin
                mode_reg       <= mode_next;
                acc_reg        <= acc_next;
                neg_reg        <= neg_next;
                kw_reg         <= kw_next;
                line_reg       <= line_next;
                pos_reg        <= pos_next;
                start_pos_reg  <= start_pos_next;
                start_line_reg <= start_line_next;
                len_reg        <= len_next;
                fresh_reg      <= fresh_next;
            end
            else if (cfg.wr && fresh_reg)
            begin
                line_reg <= cfg.data;
            end
        end
    end

endmodule

// ===== hdl/dll_out_buf.sv =====
`timescale 1ns / 1ps

module dll_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  dll_pkg::token_group_t group,
    output logic                  group_free,
    output logic                  out_valid,
    input  logic                  out_stall,
    output dll_pkg::token_t       tok,
    output logic                  last_of_run
);

    dll_pkg::token_group_t group_reg;
    logic [1:0]            idx_reg;
    logic                  busy_reg;
    logic                  beat;

    assign out_valid   = busy_reg;
    assign tok         = group_reg.tok[idx_reg];
    assign last_of_run = (2'(idx_reg + 2'd1) == group_reg.count);
    assign beat        = busy_reg && !out_stall;
    assign group_free  = !busy_reg || (beat && last_of_run);

    // Hold the token group and walk through it one beat at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (beat)
        begin
            if (last_of_run)
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Capture payload without reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            group_reg <= group;
        end
    end

endmodule

// ===== hdl/definition_language_lexer.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Beat
// in       | input     | in_valid / in_stall  | has_byte, in_byte, is_last
// out      | output    | out_valid / out_stall| one token plus last_of_run
// cfg      | input     | cfg_valid / cfg_ready| cfg_data = first_line
//
// An input item is taken when the result bank can hold its tokens; an item that
// yields two or three tokens holds the next token-bearing item back until its extra
// tokens are gone, as the result bank drains one beat per cycle while out_stall is low.
// The first token of an accepted item passes the input register, then the result bank,
// before it is offered, and a stall can hold it in between. Reset clears all control
// state; no clearing pass.
// out_stall backs up through the result bank into in_stall.

`include "assert_macros.svh"

module definition_language_lexer #(
    parameter int VALUE_WIDTH    = 32,
    parameter int POSITION_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          has_byte,
    input  logic [7:0]                    in_byte,
    input  logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    token_kind,
    output logic signed [dll_pkg::NUM_W-1:0] number_value,
    output logic [7:0]                    symbol_byte,
    output logic [dll_pkg::LINE_W-1:0]    token_line,
    output logic [dll_pkg::OFF_W-1:0]     token_offset,
    output logic [dll_pkg::LEN_W-1:0]     token_length,
    output logic                          last_of_run,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dll_pkg::LINE_W-1:0]    cfg_data
);

    logic                  in_full_reg;
    logic                  has_byte_reg;
    logic [7:0]            byte_reg;
    logic                  is_last_reg;
    logic                  item_take;
    logic                  group_free;
    logic                  load;
    dll_pkg::token_group_t group;
    dll_pkg::token_t       tok;
    dll_pkg::cfg_write_t   cfg;

    assign cfg_ready = 1'b1;
    assign cfg.wr    = cfg_valid && cfg_ready;
    assign cfg.data  = cfg_data;

    // Stall only while the held item cannot move on
    assign in_stall = in_full_reg && !item_take;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_full_reg <= 1'b1;
        end
        else if (item_take)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            has_byte_reg <= has_byte;
            byte_reg     <= in_byte;
            is_last_reg  <= is_last;
        end
    end

    dll_core #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_full_reg),
        .has_byte   (has_byte_reg),
        .in_byte    (byte_reg),
        .is_last    (is_last_reg),
        .group_free (group_free),
        .cfg        (cfg),
        .item_take  (item_take),
        .group      (group)
    );

    assign load = item_take && (group.count != 2'd0);

    dll_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .group       (group),
        .group_free  (group_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tok         (tok),
        .last_of_run (last_of_run)
    );

    assign token_kind   = tok.kind;
    assign number_value = tok.value;
    assign symbol_byte  = tok.sym;
    assign token_line   = tok.line;
    assign token_offset = tok.offset;
    assign token_length = tok.length;

    `ASSERT_IMPLY(a_stall_needs_item, clk, rst_n, in_stall, in_full_reg)
    `ASSERT_IMPLY(a_load_needs_room, clk, rst_n, load, group_free)
    `ASSERT_NEXT(a_load_shows_token, clk, rst_n, load, out_valid)
    `ASSERT_IMPLY(a_end_is_last, clk, rst_n, out_valid && token_kind == dll_pkg::KIND_END, last_of_run)

endmodule
